@@ design/move_to_front_recency_list_top_assert.svh @@
// Assertion macros for the move-to-front recency list.
// Included by the top level; relies on clk_i and rst_ni being in scope.
`ifndef MOVE_TO_FRONT_RECENCY_LIST_TOP_ASSERT_SVH
`define MOVE_TO_FRONT_RECENCY_LIST_TOP_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mtf_pkg.sv @@
// Shared types and constants for the move-to-front recency list.
// No dependencies; used by the cell and the top level.
package mtf_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 8;
  localparam logic [POS_W-1:0] POS_MAX = 8'hFF;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_PROBE  = 1'b1;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } mtf_cell_ctrl_t;

endpackage

@@ design/mtf_cell.sv @@
// One slot of the recency list: a key, a valid bit and a registered match flag.
// Depends on mtf_pkg for the key width and the control struct.
module mtf_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mtf_pkg::mtf_cell_ctrl_t ctrl_i,
  input  logic [mtf_pkg::KEY_W-1:0] search_key_i,
  input  logic [mtf_pkg::KEY_W-1:0] prev_key_i,
  input  logic                   prev_valid_i,
  output logic [mtf_pkg::KEY_W-1:0] key_o,
  output logic                   valid_o,
  output logic                   match_o
);
  import mtf_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             valid_q;
  logic             match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      key_q <= prev_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.shift_en) begin
        valid_q <= prev_valid_i;
      end
      if (ctrl_i.cmp_en) begin
        match_q <= valid_q && (key_q == search_key_i);
      end
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

@@ design/mtf_prio_tree.sv @@
// Registered binary tree that finds the lowest set bit of the match vector.
// Each level is one register stage; the root register drives found_o and index_o.
module mtf_prio_tree #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [LIST_DEPTH-1:0]         match_i,
  output logic                          found_o,
  output logic [$clog2(LIST_DEPTH)-1:0] index_o
);
  localparam int unsigned IDX_W  = $clog2(LIST_DEPTH);
  localparam int unsigned LEAVES = 2 ** IDX_W;

  logic             node_v_q   [1:LEAVES-1];
  logic [IDX_W-1:0] node_idx_q [1:LEAVES-1];

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic             left_v;
    logic             right_v;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;

    if (2 * n >= LEAVES) begin : g_leaf
      localparam int unsigned LI = 2 * n - LEAVES;
      localparam int unsigned RI = 2 * n + 1 - LEAVES;
      assign left_idx  = IDX_W'(LI);
      assign right_idx = IDX_W'(RI);
      if (LI < LIST_DEPTH) begin : g_l
        assign left_v = match_i[LI];
      end else begin : g_lpad
        assign left_v = 1'b0;
      end
      if (RI < LIST_DEPTH) begin : g_r
        assign right_v = match_i[RI];
      end else begin : g_rpad
        assign right_v = 1'b0;
      end
    end else begin : g_inner
      assign left_v    = node_v_q[2 * n];
      assign right_v   = node_v_q[2 * n + 1];
      assign left_idx  = node_idx_q[2 * n];
      assign right_idx = node_idx_q[2 * n + 1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        node_v_q[n] <= 1'b0;
      end else begin
        node_v_q[n] <= left_v || right_v;
      end
    end

    always_ff @(posedge clk_i) begin
      node_idx_q[n] <= left_v ? left_idx : right_idx;
    end
  end

  assign found_o = node_v_q[1];
  assign index_o = node_idx_q[1];

endmodule

@@ design/move_to_front_recency_list_top.sv @@
// Move-to-front recency list, top level: a row of key cells, a priority tree
// and the sequencer. Depends on mtf_pkg, mtf_cell and mtf_prio_tree.
//
// Usage: an item (req_type_i, object_key_i) is taken when in_valid_i is high
// and in_stall_o is low. An access moves a found key to the front, or inserts
// a missing key at the front and pushes every entry back by one; a probe only
// reports. Each item yields exactly one result (hit_o, position_o, evicted_o)
// on the output channel, taken when out_valid_o is high and out_stall_i is low.
// Every cell compares the key in the compare step; the registered priority
// tree then names the frontmost match in the tree step, whose length the
// depth of the tree sets; and the update step shifts the cells and loads the
// result register. One item is in work at a time, so a new item is taken
// only after the last one has left its update step.
// The result register lets the next item be taken while a result still waits.
// If the receiver stalls, the result holds and a finished item waits in its
// update step until the result register is free. Reset empties the list at
// once by clearing every valid bit; the block takes items from the first cycle.
module move_to_front_recency_list_top #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [mtf_pkg::KEY_W-1:0] object_key_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [mtf_pkg::POS_W-1:0] position_o,
  output logic                      evicted_o
);
  import mtf_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int unsigned CNT_W = $clog2(IDX_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_TREE,
    ST_UPD
  } state_e;

  state_e             state_q;
  logic               req_type_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic               hit_q;
  logic [POS_W-1:0]   position_q;
  logic               evicted_q;

  logic               in_fire;
  logic               upd_fire;
  logic               do_shift;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [PW-1:0]      found_wide;
  logic [POS_W-1:0]   position_d;
  logic               evicted_d;

  logic [KEY_W-1:0]   cell_key   [LIST_DEPTH];
  logic               cell_valid [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;
  mtf_cell_ctrl_t     cell_ctrl  [LIST_DEPTH];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign upd_fire   = (state_q == ST_UPD) && !(out_valid_q && out_stall_i);
  assign do_shift   = upd_fire && (req_type_q == REQ_ACCESS);

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = req_key_q;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i - 1];
      assign prev_valid = cell_valid[i - 1];
    end

    assign cell_ctrl[i].cmp_en   = (state_q == ST_CMP);
    assign cell_ctrl[i].shift_en = do_shift && (!found || (IDX_W'(i) <= found_idx));

    mtf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[i]),
      .search_key_i (req_key_q),
      .prev_key_i   (prev_key),
      .prev_valid_i (prev_valid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (match[i])
    );
  end

  mtf_prio_tree #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (match),
    .found_o (found),
    .index_o (found_idx)
  );

  always_comb begin
    found_wide = PW'(found_idx);
    if (!found) begin
      position_d = '0;
    end else if (found_wide > PW'(POS_MAX)) begin
      position_d = POS_MAX;
    end else begin
      position_d = found_wide[POS_W-1:0];
    end
    evicted_d = !found && (req_type_q == REQ_ACCESS) && cell_valid[LIST_DEPTH - 1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_type_q  <= REQ_ACCESS;
      req_key_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      position_q  <= '0;
      evicted_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !upd_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            req_type_q <= req_type_i;
            req_key_q  <= object_key_i;
            state_q    <= ST_CMP;
          end
        end
        ST_CMP: begin
          cnt_q   <= '0;
          state_q <= ST_TREE;
        end
        ST_TREE: begin
          if (cnt_q == CNT_W'(IDX_W - 1)) begin
            state_q <= ST_UPD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_UPD: begin
          if (upd_fire) begin
            out_valid_q <= 1'b1;
            hit_q       <= found;
            position_q  <= position_d;
            evicted_q   <= evicted_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign position_o  = position_q;
  assign evicted_o   = evicted_q;

`include "move_to_front_recency_list_top_assert.svh"

  `MTF_ASSERT_SAME(a_hit_never_evicts, out_valid_o && hit_o, !evicted_o,
                   "A hit result reports an eviction.")
  `MTF_ASSERT_SAME(a_miss_at_front, out_valid_o && !hit_o, position_o == '0,
                   "A miss result reports a nonzero position.")
  `MTF_ASSERT_NEXT(a_front_after_access, do_shift,
                   cell_valid[0] && (cell_key[0] == $past(req_key_q)),
                   "The accessed key is not at the front after an access.")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the move-to-front recency list top level.
// Drives directed and random access and probe items against a built-in predictor
// or the directed table; depends on mtf_pkg and move_to_front_recency_list_top.
`timescale 1ns / 100ps

module testbench;
  import mtf_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam int RANDOM_ITEMS = 384;
  localparam int PAUSE_AT = 240;
  localparam int LONG_HOLD_AT = 120;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT = 1000;
  localparam int DIRECTED_ROWS = 16;
  localparam int AWAIT_SLOTS = 16;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic             evicted;
  } lookup_result_t;

  typedef struct packed {
    logic             req;
    logic [KEY_W-1:0] key;
    logic             typed;
    lookup_result_t   want;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             req_type;
  logic [KEY_W-1:0] object_key;
  logic             out_valid;
  logic             out_stall;
  logic             hit;
  logic [POS_W-1:0] position;
  logic             evicted;

  logic [KEY_W-1:0] list_key [LIST_DEPTH];
  logic             list_valid [LIST_DEPTH];
  int               list_fill;
  lookup_result_t   awaited_ring [AWAIT_SLOTS];
  int               await_wr;
  int               await_rd;
  int               error_count;
  int               idle_cycles;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{REQ_PROBE,  32'h0000_0000, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'h0000_0000, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_PROBE,  32'h0000_0000, 1'b1, '{1'b1, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_PROBE,  32'h0000_0000, 1'b1, '{1'b1, 8'd1, 1'b0}},
    '{REQ_ACCESS, 32'h0000_0000, 1'b1, '{1'b1, 8'd1, 1'b0}},
    '{REQ_PROBE,  32'hFFFF_FFFF, 1'b1, '{1'b1, 8'd1, 1'b0}},
    '{REQ_ACCESS, 32'h0000_0000, 1'b1, '{1'b1, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'h1234_5678, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_PROBE,  32'hAAAA_AAAA, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'hFFFF_FFFF, 1'b0, '{1'b0, 8'd0, 1'b0}},
    '{REQ_PROBE,  32'h5555_5555, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{REQ_PROBE,  32'h1234_5678, 1'b0, '{1'b0, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'h8000_0001, 1'b0, '{1'b0, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'h7FFF_FFFE, 1'b0, '{1'b0, 8'd0, 1'b0}},
    '{REQ_ACCESS, 32'h1234_5678, 1'b0, '{1'b0, 8'd0, 1'b0}}
  };

  move_to_front_recency_list_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .object_key_i(object_key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit),
    .position_o  (position),
    .evicted_o   (evicted)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic lookup_result_t promote_or_probe(input logic req,
                                                      input logic [KEY_W-1:0] key);
    lookup_result_t res;
    int at;
    int last;
    res = '0;
    at = LIST_DEPTH;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (list_valid[i] && list_key[i] == key) at = i;
    end
    if (at < LIST_DEPTH) begin
      res.hit = 1'b1;
      res.position = (at > POS_MAX) ? POS_MAX : at[POS_W-1:0];
      last = at;
    end else begin
      res.evicted = (req == REQ_ACCESS) && list_valid[LIST_DEPTH-1];
      last = LIST_DEPTH - 1;
      if (req == REQ_ACCESS && list_fill < LIST_DEPTH) list_fill++;
    end
    if (req == REQ_ACCESS) begin
      for (int j = last; j > 0; j--) begin
        list_key[j] = list_key[j-1];
        list_valid[j] = list_valid[j-1];
      end
      list_key[0] = key;
      list_valid[0] = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  // The caller is at a falling edge; the item is left on the bus once taken.
  task automatic offer_item(input logic req, input logic [KEY_W-1:0] key,
                            input logic typed, input lookup_result_t want,
                            input bit quiet);
    int gap;
    lookup_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    object_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = promote_or_probe(req, key);
    awaited_ring[await_wr % AWAIT_SLOTS] = typed ? want : predicted;
    await_wr++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    logic req;
    int miss_pct;
    int depth_pick;
    bit quiet;
    error_count = 0;
    list_fill = 0;
    await_wr = 0;
    await_rd = 0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list_key[i] = '0;
      list_valid[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_ACCESS;
    object_key = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_item(directed_table[r].req, directed_table[r].key, directed_table[r].typed,
                 directed_table[r].want, 1'b0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (await_wr != await_rd);
      end
      quiet = ((i / 40) % 4) == 3;
      miss_pct = (list_fill < LIST_DEPTH) ? 95 : 40;
      if (list_fill == 0 || $urandom_range(0, 99) < miss_pct) begin
        key = $urandom;
      end else begin
        depth_pick = ($urandom_range(0, 7) == 0) ? list_fill - 1
                                                 : $urandom_range(0, list_fill - 1);
        key = list_key[depth_pick];
      end
      req = ($urandom_range(0, 7) == 0) ? REQ_PROBE : REQ_ACCESS;
      offer_item(req, key, 1'b0, '0, quiet);
    end
    in_valid <= 1'b0;
    while (await_wr != await_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS move_to_front_recency_list_top");
    end else begin
      $display("FAIL move_to_front_recency_list_top");
    end
    $finish;
  end

  initial begin : receiver
    int hold;
    int taken;
    taken = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      else if (((taken / 30) % 4) == 2) hold = 0;
      else hold = $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (await_wr == await_rd) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = awaited_ring[await_rd % AWAIT_SLOTS];
        await_rd++;
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (position !== want.position) report_mismatch("position", position, want.position);
        if (evicted !== want.evicted) report_mismatch("evicted", evicted, want.evicted);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL move_to_front_recency_list_top");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule

@@ filelist.f @@
+incdir+design
design/mtf_pkg.sv
design/mtf_cell.sv
design/mtf_prio_tree.sv
design/move_to_front_recency_list_top.sv
bench/testbench.sv
